// ===== src/rvts_pkg.sv =====
// Package: shared types and constants for the realized variance tail share block.
`default_nettype none
package rvts_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int PRICE_W         = 32;
  localparam int WS_W            = 12;
  localparam int SHARE_W         = 17;
  localparam int SUM_W           = 64;
  localparam int LOG_W           = 36;
  localparam int LOG_STEPS       = 30;
  localparam int DIV_STEPS       = 16;

  localparam logic [WS_W-1:0]    WS_RESET   = 12'd360;
  localparam logic [31:0]        LN2_Q32    = 32'd2977044472;
  localparam logic [SUM_W-1:0]   SUM_CAP    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [30:0]        RET_MAX    = 31'h7FFF_FFFF;
  localparam logic [SHARE_W-1:0] SHARE_ONE  = 17'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOG,
    ST_RMUL,
    ST_SQ,
    ST_UPD,
    ST_DINIT,
    ST_DSTEP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic log_step;
    logic ret_mul;
    logic sq_mul;
    logic update;
    logic div_init;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic do_ret;
    logic last;
    logic log_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== src/realized_variance_tail_share_top.sv =====
// Top level: realized variance tail share, controller plus datapath.
// A sample with a valid price runs 30 log2 squaring steps on one 31x31 multiplier, then
// two return multiplies when it has a return, then one accumulate. An invalid price skips
// the log. A last sample adds a restoring divide, then the share word waits in an output
// register while the next sample is accepted; any output stall delays the result.
// Synchronous active-low reset clears series state, sets window_start to 360, empties output.
`default_nettype none
module realized_variance_tail_share_top #(
  parameter int MAX_SAMPLES = rvts_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [rvts_pkg::PRICE_W-1:0] in_price,
  input  wire logic                                in_price_valid,
  input  wire logic                                in_last_sample,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [rvts_pkg::SHARE_W-1:0]             out_share,
  output logic                                     out_share_valid,
  input  wire logic                                cfg_wr_en,
  input  wire logic [rvts_pkg::WS_W-1:0]           cfg_wr_data
);
  import rvts_pkg::*;

  cmd_t    cmd;
  status_t sts;

  rvts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rvts_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_price        (in_price),
    .in_price_valid  (in_price_valid),
    .in_last_sample  (in_last_sample),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_share       (out_share),
    .out_share_valid (out_share_valid),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
`default_nettype wire

// ===== src/rvts_ctrl.sv =====
// Controller: sequences log, return, accumulate and (last word) divide steps.
`default_nettype none
module rvts_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  rvts_pkg::status_t     sts,
  output rvts_pkg::cmd_t        cmd
);
  import rvts_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOG;
        end
      end
      ST_LOG: begin
        // skip the log entirely for an invalid price
        if (!sts.ok) begin
          state_nxt = ST_UPD;
        end else if (sts.log_done) begin
          state_nxt = sts.do_ret ? ST_RMUL : ST_UPD;
        end else begin
          cmd.log_step = 1'b1;
        end
      end
      ST_RMUL: begin
        cmd.ret_mul = 1'b1;
        state_nxt   = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq_mul = 1'b1;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = sts.last ? ST_DINIT : ST_IDLE;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DSTEP;
      end
      ST_DSTEP: begin
        if (sts.div_done) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FIN: begin
        // hold until the output register can take the word
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/rvts_dp.sv =====
// Datapath: log2 squaring unit, return multiplies, sums, divider and output register.
`default_nettype none
module rvts_dp #(
  parameter int MAX_SAMPLES = rvts_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic signed [rvts_pkg::PRICE_W-1:0] in_price,
  input  wire logic                              in_price_valid,
  input  wire logic                              in_last_sample,
  input  wire logic                              cfg_wr_en,
  input  wire logic [rvts_pkg::WS_W-1:0]         cfg_wr_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [rvts_pkg::SHARE_W-1:0]           out_share,
  output logic                                   out_share_valid,
  input  rvts_pkg::cmd_t                         cmd,
  output rvts_pkg::status_t                      sts
);
  import rvts_pkg::*;

  localparam int POS_W = $clog2(MAX_SAMPLES);
  localparam int CMP_W = (POS_W > WS_W) ? POS_W : WS_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SAMPLES - 1);

  logic [WS_W-1:0]      window_r;
  logic [POS_W-1:0]     position_r, t_r;
  logic [POS_W-1:0]     total_count_r, tail_count_r;
  logic [SUM_W-1:0]     total_sum_r, tail_sum_r;
  logic                 prev_ok_r, ok_r, last_r, do_ret_r;
  logic signed [LOG_W-1:0] prev_log_r;
  logic [4:0]           m_r, lcnt_r;
  logic [30:0]          y_r;
  logic [29:0]          frac_r;
  logic [63:0]          prod_r;
  logic                 rsat_r;
  logic [45:0]          sq_r;
  logic [SUM_W-1:0]     rem_r;
  logic [17:0]          q_r;
  logic [4:0]           dcnt_r;
  logic                 out_valid_r, out_sv_r;
  logic [SHARE_W-1:0]   out_share_r;

  // normalization of the incoming price
  logic        p_ok;
  logic [4:0]  msb;
  logic [30:0] y0;
  always_comb begin
    msb = '0;
    for (int i = 0; i < 31; i++) begin
      if (in_price[i]) msb = 5'(i);
    end
    p_ok = in_price_valid && (in_price[30:0] != '0) && !in_price[31];
    y0   = 31'(in_price[30:0] << (5'd30 - msb));
  end

  // one squaring step of the log2 fraction
  logic [61:0] ysq;
  logic [31:0] ysh;
  assign ysq = y_r * y_r;
  assign ysh = ysq[61:30];

  // current log2, Q.30 signed
  logic signed [5:0]       expo;
  logic signed [LOG_W-1:0] cur_log;
  logic signed [LOG_W:0]   dlog;
  logic [LOG_W:0]          dmag;
  assign expo    = $signed({1'b0, m_r}) - 6'sd16;
  assign cur_log = {expo, frac_r};
  assign dlog    = LOG_W'(cur_log) - LOG_W'(prev_log_r);
  assign dmag    = dlog[LOG_W] ? LOG_W'(-dlog) : LOG_W'(dlog);

  // rounded return and its square
  logic [32:0] rnd;
  logic [30:0] ret;
  logic [61:0] rsq;
  assign rnd = 33'((prod_r + 64'h8000_0000) >> 32);
  assign ret = (rsat_r || rnd > 33'(RET_MAX)) ? RET_MAX : rnd[30:0];
  assign rsq = ret * ret;

  // saturating adds
  logic [SUM_W:0] tot_add, tail_add;
  assign tot_add  = {1'b0, total_sum_r} + {18'd0, sq_r};
  assign tail_add = {1'b0, tail_sum_r} + {18'd0, sq_r};
  logic tail_hit;
  assign tail_hit = CMP_W'(t_r) >= CMP_W'(window_r);

  // divider steps
  logic [SUM_W-1:0] r1, rsh;
  assign r1  = tail_sum_r - total_sum_r;
  assign rsh = {rem_r[SUM_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r      <= WS_RESET;
      position_r    <= '0;
      total_count_r <= '0;
      tail_count_r  <= '0;
      total_sum_r   <= '0;
      tail_sum_r    <= '0;
      prev_ok_r     <= 1'b0;
      prev_log_r    <= '0;
      out_valid_r   <= 1'b0;
      lcnt_r        <= '0;
      dcnt_r        <= '0;
    end else begin
      if (cfg_wr_en) window_r <= cfg_wr_data;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.load) begin
        ok_r     <= p_ok;
        last_r   <= in_last_sample;
        t_r      <= position_r;
        do_ret_r <= (position_r != '0) && p_ok && prev_ok_r;
        m_r      <= msb;
        y_r      <= y0;
        frac_r   <= '0;
        lcnt_r   <= '0;
      end
      if (cmd.log_step) begin
        frac_r <= {frac_r[28:0], ysh[31]};
        y_r    <= ysh[31] ? ysh[31:1] : ysh[30:0];
        lcnt_r <= lcnt_r + 5'd1;
      end
      if (cmd.ret_mul) begin
        prod_r <= dmag[31:0] * LN2_Q32;
        rsat_r <= dmag >= (LOG_W+1)'(64'h3 << 30);
      end
      if (cmd.sq_mul) begin
        sq_r <= rsq[61:16];
      end
      if (cmd.update) begin
        if (do_ret_r) begin
          total_sum_r <= tot_add[SUM_W-1] ? SUM_CAP : tot_add[SUM_W-1:0];
          if (total_count_r != POS_MAX) total_count_r <= total_count_r + 1'b1;
          if (tail_hit) begin
            tail_sum_r <= tail_add[SUM_W-1] ? SUM_CAP : tail_add[SUM_W-1:0];
            if (tail_count_r != POS_MAX) tail_count_r <= tail_count_r + 1'b1;
          end
        end
        prev_ok_r  <= ok_r;
        prev_log_r <= cur_log;
        if (position_r != POS_MAX) position_r <= position_r + 1'b1;
      end
      if (cmd.div_init) begin
        dcnt_r <= '0;
        if (tail_sum_r >= total_sum_r) begin
          q_r   <= 18'd1;
          rem_r <= (r1 >= total_sum_r) ? '0 : r1;
        end else begin
          q_r   <= '0;
          rem_r <= tail_sum_r;
        end
      end
      if (cmd.div_step) begin
        dcnt_r <= dcnt_r + 5'd1;
        if (rsh >= total_sum_r) begin
          rem_r <= rsh - total_sum_r;
          q_r   <= {q_r[16:0], 1'b1};
        end else begin
          rem_r <= rsh;
          q_r   <= {q_r[16:0], 1'b0};
        end
      end
      if (cmd.finish) begin
        if (total_count_r != '0 && tail_count_r != '0 && total_sum_r != '0) begin
          out_sv_r    <= 1'b1;
          out_share_r <= (q_r > 18'(SHARE_ONE)) ? SHARE_ONE : q_r[SHARE_W-1:0];
        end else begin
          out_sv_r    <= 1'b0;
          out_share_r <= '0;
        end
        // drop the series state
        position_r    <= '0;
        total_count_r <= '0;
        tail_count_r  <= '0;
        total_sum_r   <= '0;
        tail_sum_r    <= '0;
        prev_ok_r     <= 1'b0;
        prev_log_r    <= '0;
      end
    end
  end

  assign sts.ok       = ok_r;
  assign sts.do_ret   = do_ret_r;
  assign sts.last     = last_r;
  assign sts.log_done = (lcnt_r == 5'(LOG_STEPS));
  assign sts.div_done = (dcnt_r == 5'(DIV_STEPS));
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_share       = out_share_r;
  assign out_share_valid = out_sv_r;

endmodule
`default_nettype wire
